/* design/activity_max_heap_macros.svh */
// Assertion macros shared by the activity max-heap RTL.
// No dependencies; the including module must provide clk and arst_n.
`ifndef ACTIVITY_MAX_HEAP_MACROS_SVH
`define ACTIVITY_MAX_HEAP_MACROS_SVH

// cons must hold in the same cycle as ante
`define AMH_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define AMH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/amh_pkg.sv */
// Package for the activity max-heap: item field widths, item kinds,
// sequencer states and the structs passed between engine and top level.
`timescale 1ns / 1ps

package amh_pkg;

	localparam int VAR_W    = 10;
	localparam int KEY_IN_W = 32;
	localparam int KIND_W   = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_KEY    = 2'd2;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CHK,
		ST_UP_RD,
		ST_UP_KEY,
		ST_UP_CMP,
		ST_UP_END,
		ST_POP_RD,
		ST_POP_LAST,
		ST_POP_KEY,
		ST_POP_KEY2,
		ST_DN_L,
		ST_DN_R,
		ST_DN_RK,
		ST_DN_CMP,
		ST_DN_END,
		ST_KEY_WR,
		ST_DONE
	} amh_state_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [VAR_W-1:0]    variable;
		logic [KEY_IN_W-1:0] key;
	} amh_cmd_t;

	typedef struct packed {
		logic [VAR_W-1:0] popped_variable;
		logic             heap_was_empty;
	} amh_result_t;

	typedef struct packed {
		logic ready;   // engine idle, can take a command
		logic done;    // result handed over this cycle
	} amh_stat_t;

endpackage

/* design/amh_req_if.sv */
// Input channel of the activity max-heap: valid/ready plus one command item.
// Depends on amh_pkg.
`timescale 1ns / 1ps

interface amh_req_if;
	import amh_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [VAR_W-1:0]    variable;
	logic [KEY_IN_W-1:0] key;

	modport source (output valid, output kind, output variable, output key, input ready);
	modport sink   (input valid, input kind, input variable, input key, output ready);
endinterface

/* design/amh_rsp_if.sv */
// Result channel of the activity max-heap: valid/ready plus one result item.
// Depends on amh_pkg.
`timescale 1ns / 1ps

interface amh_rsp_if;
	import amh_pkg::*;

	logic             valid;
	logic             ready;
	logic [VAR_W-1:0] popped_variable;
	logic             heap_was_empty;

	modport source (output valid, output popped_variable, output heap_was_empty, input ready);
	modport sink   (input valid, input popped_variable, input heap_was_empty, output ready);
endinterface

/* design/amh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module amh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/amh_engine.sv */
// Heap sequencer: three RAMs (heap order, position map, activity keys) and
// key comparators stepped through sift-up / sift-down by a small FSM.
// Depends on amh_pkg and amh_ram.
`timescale 1ns / 1ps

module amh_engine #(
	parameter int NUM_VARS  = 1023,
	parameter int KEY_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  amh_pkg::amh_cmd_t   cmd,
	input  logic                res_ready,
	output amh_pkg::amh_stat_t  stat,
	output amh_pkg::amh_result_t result
);
	import amh_pkg::*;

	localparam int SLOT_W = (NUM_VARS > 2) ? $clog2(NUM_VARS) : 1;
	localparam int CNT_W  = $clog2(NUM_VARS + 1);
	localparam int VA_W   = $clog2(NUM_VARS + 1);
	localparam int CH_W   = SLOT_W + 2;
	localparam int SM_W   = SLOT_W + 1;
	localparam int KEXT_W = (KEY_WIDTH > KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;

	amh_state_t state_q, state_d;

	logic [CNT_W-1:0]     count_q;
	logic [VA_W-1:0]      clr_q;
	logic [SLOT_W-1:0]    pos_q;
	logic [VAR_W-1:0]     cur_var_q;
	logic [KEY_WIDTH-1:0] cur_key_q;
	logic [VAR_W-1:0]     top_q;
	logic [VAR_W-1:0]     bv_q;
	logic [VAR_W-1:0]     rv_q;
	logic [KEY_WIDTH-1:0] lkey_q;
	logic [VAR_W-1:0]     var_q;
	logic [KEY_WIDTH-1:0] key_q;
	amh_result_t          res_q;

	// RAM ports
	logic                 heap_we;
	logic [SLOT_W-1:0]    heap_waddr, heap_raddr;
	logic [VAR_W-1:0]     heap_wdata, heap_rdata;
	logic                 sm_we;
	logic [VA_W-1:0]      sm_waddr, sm_raddr;
	logic [SM_W-1:0]      sm_wdata, sm_rdata;
	logic                 key_we;
	logic [VA_W-1:0]      key_waddr, key_raddr;
	logic [KEY_WIDTH-1:0] key_wdata, key_rdata;

	logic [KEXT_W-1:0]    key_ext;
	logic [KEY_WIDTH-1:0] key_in;
	logic                 var_ok;
	logic [SLOT_W-1:0]    pos_m1, parent;
	logic [CH_W-1:0]      left_c, right_c, cnt_c;
	logic                 l_ok, r_ok;
	logic                 up_move;
	logic                 take_l, take_r;
	logic [KEY_WIDTH-1:0] best_key;

	assign key_ext = KEXT_W'(cmd.key);
	assign key_in  = key_ext[KEY_WIDTH-1:0];
	assign var_ok  = (cmd.variable != '0) && (32'(cmd.variable) <= 32'(NUM_VARS));

	assign pos_m1  = pos_q - SLOT_W'(1);
	assign parent  = pos_m1 >> 1;
	assign left_c  = {1'b0, pos_q, 1'b1};
	assign right_c = left_c + CH_W'(1);
	assign cnt_c   = CH_W'(count_q);
	assign l_ok    = left_c < cnt_c;
	assign r_ok    = right_c < cnt_c;

	// key comparators: sift-up against the parent, sift-down against the children
	assign up_move  = key_rdata < cur_key_q;
	assign take_l   = lkey_q > cur_key_q;
	assign best_key = take_l ? lkey_q : cur_key_q;
	assign take_r   = r_ok && (key_rdata > best_key);

	amh_ram #(.WIDTH(VAR_W), .DEPTH(NUM_VARS)) u_heap_ram (
		.clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
		.raddr(heap_raddr), .rdata(heap_rdata)
	);

	amh_ram #(.WIDTH(SM_W), .DEPTH(NUM_VARS + 1)) u_slot_ram (
		.clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
		.raddr(sm_raddr), .rdata(sm_rdata)
	);

	amh_ram #(.WIDTH(KEY_WIDTH), .DEPTH(NUM_VARS + 1)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
		.raddr(key_raddr), .rdata(key_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == VA_W'(NUM_VARS)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					case (cmd.kind)
						KIND_INSERT: state_d = var_ok ? ST_INS_RD : ST_DONE;
						KIND_POP:    state_d = (count_q == '0) ? ST_DONE : ST_POP_RD;
						KIND_KEY:    state_d = var_ok ? ST_KEY_WR : ST_DONE;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_INS_RD: state_d = ST_INS_CHK;
			ST_INS_CHK: begin
				if (sm_rdata[SM_W-1] || count_q == CNT_W'(NUM_VARS)) state_d = ST_DONE;
				else state_d = ST_UP_RD;
			end
			ST_UP_RD:    state_d = (pos_q == '0) ? ST_UP_END : ST_UP_KEY;
			ST_UP_KEY:   state_d = ST_UP_CMP;
			ST_UP_CMP:   state_d = up_move ? ST_UP_RD : ST_UP_END;
			ST_UP_END:   state_d = ST_DONE;
			ST_POP_RD:   state_d = ST_POP_LAST;
			ST_POP_LAST: state_d = ST_POP_KEY;
			ST_POP_KEY:  state_d = (count_q == '0) ? ST_DONE : ST_POP_KEY2;
			ST_POP_KEY2: state_d = ST_DN_L;
			ST_DN_L:     state_d = l_ok ? ST_DN_R : ST_DN_END;
			ST_DN_R:     state_d = ST_DN_RK;
			ST_DN_RK:    state_d = ST_DN_CMP;
			ST_DN_CMP:   state_d = (take_l || take_r) ? ST_DN_L : ST_DN_END;
			ST_DN_END:   state_d = ST_DONE;
			ST_KEY_WR:   state_d = ST_DONE;
			ST_DONE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// RAM controls and status
	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = pos_q;
		heap_wdata = cur_var_q;
		heap_raddr = left_c[SLOT_W-1:0];
		sm_we      = 1'b0;
		sm_waddr   = VA_W'(cur_var_q);
		sm_wdata   = {1'b1, pos_q};
		sm_raddr   = VA_W'(var_q);
		key_we     = 1'b0;
		key_waddr  = VA_W'(var_q);
		key_wdata  = key_q;
		key_raddr  = VA_W'(var_q);
		stat.ready = 1'b0;
		stat.done  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				sm_we     = 1'b1;
				sm_waddr  = clr_q;
				sm_wdata  = '0;
				key_we    = 1'b1;
				key_waddr = clr_q;
				key_wdata = '0;
			end
			ST_IDLE:   stat.ready = 1'b1;
			ST_UP_RD:  heap_raddr = parent;
			ST_UP_KEY: key_raddr = VA_W'(heap_rdata);
			ST_UP_CMP: begin
				// parent moves down into the hole
				heap_we    = up_move;
				heap_wdata = bv_q;
				sm_we      = up_move;
				sm_waddr   = VA_W'(bv_q);
			end
			ST_UP_END, ST_DN_END: begin
				heap_we = 1'b1;
				sm_we   = 1'b1;
			end
			ST_POP_RD:   heap_raddr = '0;
			ST_POP_LAST: heap_raddr = SLOT_W'(count_q);
			ST_POP_KEY: begin
				key_raddr = VA_W'(heap_rdata);
				sm_we     = 1'b1;
				sm_waddr  = VA_W'(top_q);
				sm_wdata  = '0;
			end
			ST_DN_R: begin
				key_raddr  = VA_W'(heap_rdata);
				heap_raddr = right_c[SLOT_W-1:0];
			end
			ST_DN_RK: key_raddr = VA_W'(heap_rdata);
			ST_DN_CMP: begin
				// larger child moves up into the hole
				heap_we    = take_l || take_r;
				heap_wdata = take_r ? rv_q : bv_q;
				sm_we      = take_l || take_r;
				sm_waddr   = VA_W'(take_r ? rv_q : bv_q);
			end
			ST_KEY_WR: key_we = 1'b1;
			ST_DONE:   stat.done = res_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + VA_W'(1);
			if (state_q == ST_POP_RD) count_q <= count_q - CNT_W'(1);
			if (state_q == ST_INS_CHK && state_d == ST_UP_RD) count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					var_q     <= cmd.variable;
					cur_var_q <= cmd.variable;
					key_q     <= key_in;
					res_q.popped_variable <= '0;
					res_q.heap_was_empty  <= (cmd.kind == KIND_POP) && (count_q == '0);
				end
			end
			ST_INS_CHK: begin
				cur_key_q <= key_rdata;
				pos_q     <= SLOT_W'(count_q);
			end
			ST_UP_KEY: bv_q <= heap_rdata;
			ST_UP_CMP: begin
				if (up_move) pos_q <= parent;
			end
			ST_POP_LAST: begin
				top_q <= heap_rdata;
				res_q.popped_variable <= heap_rdata;
			end
			ST_POP_KEY: begin
				cur_var_q <= heap_rdata;
				pos_q     <= '0;
			end
			ST_POP_KEY2: cur_key_q <= key_rdata;
			ST_DN_R:     bv_q <= heap_rdata;
			ST_DN_RK: begin
				lkey_q <= key_rdata;
				rv_q   <= heap_rdata;
			end
			ST_DN_CMP: begin
				if (take_r) pos_q <= right_c[SLOT_W-1:0];
				else if (take_l) pos_q <= left_c[SLOT_W-1:0];
			end
			default: ;
		endcase
	end

	assign result = res_q;

endmodule

/* design/activity_max_heap.sv */
// Activity max-heap top level: request/result channels, result register
// and the heap sequencer. Depends on amh_pkg, amh_req_if, amh_rsp_if,
// amh_engine and activity_max_heap_macros.svh.
`timescale 1ns / 1ps
`include "activity_max_heap_macros.svh"

// Indexed binary max-heap of variable numbers keyed by activity. One item
// at a time: req.ready is high only while the sequencer is idle. All heap,
// position-map and key accesses go through RAMs with one registered read
// port each, so cost is set by reads per heap level: an insert climbs
// level by level from the new last slot, a pop descends level by level
// from the root, and a key write, an ignored item, an empty pop, a pop
// that empties the heap or an insert of a present variable walks no levels.
// Each item ends by waiting until the result register can take its result.
// After reset a clearing pass over addresses 0 to NUM_VARS zeroes keys and
// marks every variable absent; no item is taken until it ends. The result
// register lets the next item in while the previous result is still
// waiting on rsp.
module activity_max_heap #(
	parameter int NUM_VARS  = 1023,
	parameter int KEY_WIDTH = 32
) (
	input logic   clk,
	input logic   arst_n,
	amh_req_if.sink   req,
	amh_rsp_if.source rsp
);
	import amh_pkg::*;

	amh_cmd_t    cmd;
	amh_stat_t   eng_stat;
	amh_result_t eng_result;
	amh_result_t out_q;
	logic        out_valid_q;
	logic        res_ready;
	logic        pop_empty_out;

	assign cmd.kind     = req.kind;
	assign cmd.variable = req.variable;
	assign cmd.key      = req.key;
	assign req.ready    = eng_stat.ready;
	assign res_ready    = !out_valid_q || rsp.ready;

	amh_engine #(.NUM_VARS(NUM_VARS), .KEY_WIDTH(KEY_WIDTH)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req.valid && req.ready),
		.cmd       (cmd),
		.res_ready (res_ready),
		.stat      (eng_stat),
		.result    (eng_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_stat.done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_stat.done) out_q <= eng_result;
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.popped_variable = out_q.popped_variable;
	assign rsp.heap_was_empty  = out_q.heap_was_empty;

	assign pop_empty_out = rsp.valid && rsp.heap_was_empty;

	`AMH_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "two items taken")
	`AMH_ASSERT_IMPLY(a_no_overrun, eng_stat.done, !out_valid_q || rsp.ready, "result overwritten")
	`AMH_ASSERT_IMPLY(a_empty_pop_zero, pop_empty_out, rsp.popped_variable == '0, "var on empty pop")

endmodule

/* tb/tb_top.sv */
// Testbench for activity_max_heap: drives insert, pop, key-write and no-op items and checks each
// result against a heap kept in the bench. Depends on amh_pkg, amh_req_if, amh_rsp_if and activity_max_heap.
`timescale 1ns / 1ps

module tb_top;
	import amh_pkg::*;

	localparam int NUM_VARS = 1023;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;   // no effect, zero result

	logic clk;
	logic arst_n;

	amh_req_if req_ch ();
	amh_rsp_if rsp_ch ();

	activity_max_heap #(
		.NUM_VARS (NUM_VARS),
		.KEY_WIDTH(32)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// bench copy of the heap
	bit [VAR_W-1:0] heap_slot [0:NUM_VARS-1];
	bit             in_heap   [0:NUM_VARS];
	bit [31:0]      act_key   [0:NUM_VARS];
	int             live_count;

	amh_result_t heap_outcome_q [$];

	int send_idle_pct;
	int rsp_idle_pct;
	int hold_len;
	logic rsp_held;

	int mismatch_count;
	int items_sent;
	int pops_taken;
	int pops_empty;
	int heap_peak;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void swap_slots(int a, int b);
		bit [VAR_W-1:0] va, vb;
		va = heap_slot[a];
		vb = heap_slot[b];
		heap_slot[a] = vb;
		heap_slot[b] = va;
	endfunction

	// climb while the parent key is strictly smaller
	function automatic void sift_up(int p);
		bit [31:0] k;
		int parent;
		k = act_key[heap_slot[p]];
		while (p > 0) begin
			parent = (p - 1) / 2;
			if (act_key[heap_slot[parent]] >= k)
				break;
			swap_slots(parent, p);
			p = parent;
		end
	endfunction

	// strict compares, left child wins ties against right
	function automatic void sift_down(int p);
		int l, r, best;
		bit settled;
		settled = 1'b0;
		while (!settled) begin
			l = 2 * p + 1;
			r = 2 * p + 2;
			best = p;
			if (l < live_count && act_key[heap_slot[l]] > act_key[heap_slot[best]])
				best = l;
			if (r < live_count && act_key[heap_slot[r]] > act_key[heap_slot[best]])
				best = r;
			if (best == p)
				settled = 1'b1;
			else begin
				swap_slots(p, best);
				p = best;
			end
		end
	endfunction

	function automatic amh_result_t heap_apply(logic [KIND_W-1:0] kind, logic [VAR_W-1:0] vnum,
			logic [KEY_IN_W-1:0] k);
		amh_result_t res;
		bit [VAR_W-1:0] top, moved;
		int p;
		res = '0;
		case (kind)
			KIND_INSERT: begin
				if (vnum != 0 && !in_heap[vnum] && live_count < NUM_VARS) begin
					p = live_count;
					live_count++;
					heap_slot[p] = vnum;
					in_heap[vnum] = 1'b1;
					sift_up(p);
					if (live_count > heap_peak)
						heap_peak = live_count;
				end
			end
			KIND_POP: begin
				if (live_count == 0) begin
					res.heap_was_empty = 1'b1;
					pops_empty++;
				end else begin
					top = heap_slot[0];
					live_count--;
					moved = heap_slot[live_count];
					heap_slot[0] = moved;
					in_heap[top] = 1'b0;
					sift_down(0);
					res.popped_variable = top;
					pops_taken++;
				end
			end
			KIND_KEY: begin
				if (vnum != 0)
					act_key[vnum] = k;   // no reorder
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic send_item(logic [KIND_W-1:0] kind, logic [VAR_W-1:0] vnum,
			logic [KEY_IN_W-1:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.kind     <= kind;
		req_ch.variable <= vnum;
		req_ch.key      <= k;
		do
			@(posedge clk);
		while (!req_ch.ready);
		heap_outcome_q.push_back(heap_apply(kind, vnum, k));
		items_sent++;
	endtask

	function automatic logic [KEY_IN_W-1:0] rand_key();
		int sel;
		sel = $urandom_range(9);
		if (sel < 4)
			return $urandom_range(7);   // narrow range forces ties
		else if (sel < 8)
			return $urandom;
		else if (sel == 8)
			return '0;
		return '1;
	endfunction

	function automatic logic [VAR_W-1:0] rand_variable();
		int sel;
		sel = $urandom_range(9);
		if (sel < 5)
			return VAR_W'($urandom_range(1, 24));   // small pool: duplicates, re-inserts
		else if (sel < 9)
			return VAR_W'($urandom_range(1, NUM_VARS));
		return $urandom_range(1) ? 10'd0 : 10'(NUM_VARS);
	endfunction

	// result check and receiver ready
	always @(posedge clk) begin
		amh_result_t exp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (heap_outcome_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with nothing pending: var %0d empty %0b", $realtime,
						rsp_ch.popped_variable, rsp_ch.heap_was_empty);
			end else begin
				exp = heap_outcome_q.pop_front();
				if (rsp_ch.popped_variable !== exp.popped_variable ||
						rsp_ch.heap_was_empty !== exp.heap_was_empty) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: mismatch: var exp %0d got %0d, empty exp %0b got %0b",
							$realtime, exp.popped_variable, rsp_ch.popped_variable,
							exp.heap_was_empty, rsp_ch.heap_was_empty);
				end
			end
		end
		rsp_ch.ready <= !rsp_held && ($urandom_range(99) >= rsp_idle_pct);
	end

	// long receiver hold-off, counted here
	initial begin
		rsp_held = 1'b0;
		wait (hold_len != 0);
		@(posedge clk);
		rsp_held <= 1'b1;
		repeat (hold_len) @(posedge clk);
		rsp_held <= 1'b0;
	end

	task automatic test_directed_corners();
		send_item(KIND_POP, 10'd0, '0);            // empty heap
		send_item(KIND_NONE, 10'd0, '0);
		send_item(KIND_INSERT, 10'd0, '0);         // variable zero ignored
		send_item(KIND_KEY, 10'd0, 32'hFFFF_FFFF);
		send_item(KIND_KEY, 10'(NUM_VARS), 32'hFFFF_FFFF);
		send_item(KIND_KEY, 10'd512, 32'h8000_0000);
		send_item(KIND_KEY, 10'd2, 32'd5);
		send_item(KIND_INSERT, 10'd1, '0);
		send_item(KIND_INSERT, 10'd2, '0);
		send_item(KIND_INSERT, 10'(NUM_VARS), '0);
		send_item(KIND_INSERT, 10'd512, '0);
		send_item(KIND_INSERT, 10'(NUM_VARS), '0); // already present
		send_item(KIND_INSERT, 10'd3, '0);         // equal key to var 1
		send_item(KIND_KEY, 10'd1, 32'hFFFF_FFFF); // key change, heap left as is
		send_item(KIND_NONE, 10'h3FF, 32'hFFFF_FFFF);
		repeat (6) send_item(KIND_POP, 10'h3FF, 32'hFFFF_FFFF);
	endtask

	task automatic test_random_mix(int n);
		int sel;
		repeat (n) begin
			sel = $urandom_range(99);
			if (sel < 40)
				send_item(KIND_INSERT, rand_variable(), $urandom);
			else if (sel < 70)
				send_item(KIND_POP, VAR_W'($urandom), $urandom);
			else if (sel < 95)
				send_item(KIND_KEY, rand_variable(), rand_key());
			else
				send_item(KIND_NONE, VAR_W'($urandom), $urandom);
		end
	endtask

	task automatic test_result_backpressure();
		hold_len = 400;
		repeat (10) begin
			send_item(KIND_INSERT, rand_variable(), '0);
			send_item(KIND_POP, '0, '0);
		end
	endtask

	// grow the heap several levels deep, then drain much of it
	task automatic test_deep_fill_drain();
		logic [VAR_W-1:0] v;
		repeat (300) begin
			v = VAR_W'($urandom_range(1, NUM_VARS));
			send_item(KIND_KEY, v, rand_key());
			send_item(KIND_INSERT, v, '0);
		end
		repeat (200) send_item(KIND_POP, '0, '0);
	endtask

	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.kind     = KIND_INSERT;
		req_ch.variable = '0;
		req_ch.key      = '0;
		hold_len        = 0;
		live_count      = 0;
		mismatch_count  = 0;
		items_sent      = 0;
		pops_taken      = 0;
		pops_empty      = 0;
		heap_peak       = 0;
		send_idle_pct   = 31;
		rsp_idle_pct    = 62;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_corners();
		test_random_mix(250);
		send_idle_pct = 62;
		rsp_idle_pct  = 31;
		test_random_mix(250);
		send_idle_pct = 0;
		rsp_idle_pct  = 0;
		test_result_backpressure();
		test_random_mix(250);
		test_deep_fill_drain();

		req_ch.valid <= 1'b0;
		while (heap_outcome_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		if (heap_outcome_q.size() != 0)
			mismatch_count += heap_outcome_q.size();
		$display("Sent %0d items: %0d pops returned a variable, %0d found the heap empty.",
			items_sent, pops_taken, pops_empty);
		$display("Heap peaked at %0d entries; %0d mismatches.", heap_peak, mismatch_count);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/amh_pkg.sv
design/amh_req_if.sv
design/amh_rsp_if.sv
design/amh_ram.sv
design/amh_engine.sv
design/activity_max_heap.sv
tb/tb_top.sv
